// ===== design/csrmv_pkg.sv =====
// Shared types and constants for the CSR sparse row engine.
`timescale 1ns / 1ps
`default_nettype none

package csrmv_pkg;

  // Operation codes of an input item; code 3 has no meaning and is dropped.
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_MAC   = 2'd1,
    OP_CLOSE = 2'd2
  } op_e;

  localparam int unsigned VECTOR_DEPTH_DEF = 1024;
  localparam int unsigned DATA_WIDTH_DEF   = 32;
  localparam int unsigned QUEUE_DEPTH      = 4;
  localparam int unsigned FRAC_BITS        = 16;
  localparam int unsigned ACC_WIDTH        = 64;

  typedef struct packed {
    logic [1:0]          operation;
    logic [9:0]          position;
    logic signed [31:0]  datum;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0]  row_sum;
    logic [15:0]         row_number;
    logic                saturated;
  } out_item_t;

endpackage

`default_nettype wire

// ===== design/csrmv_front.sv =====
// Front end: accepts items, drops meaningless ones and packs queue entries.
`timescale 1ns / 1ps
`default_nettype none

module csrmv_front #(
  parameter int unsigned VECTOR_DEPTH = csrmv_pkg::VECTOR_DEPTH_DEF,
  parameter int unsigned DATA_WIDTH   = csrmv_pkg::DATA_WIDTH_DEF,
  localparam int unsigned AddrWidth   = $clog2(VECTOR_DEPTH),
  localparam int unsigned EntryWidth  = 2 + AddrWidth + DATA_WIDTH
) (
  input  wire logic                     in_valid_i,
  input  wire csrmv_pkg::in_item_t      in_item_i,
  output logic                          in_stall_o,
  input  wire logic                     q_full_i,
  output logic                          q_push_o,
  output logic [EntryWidth-1:0]         q_entry_o
);

  logic                  accept;
  logic                  in_range;
  logic                  keep;
  logic [AddrWidth-1:0]  addr;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign in_range   = 32'(in_item_i.position) < VECTOR_DEPTH;
  assign addr       = AddrWidth'(in_item_i.position);

  // Out-of-range loads and nonzeros, and the unused code, leave no trace.
  always_comb begin
    case (in_item_i.operation)
      csrmv_pkg::OP_LOAD:  keep = in_range;
      csrmv_pkg::OP_MAC:   keep = in_range;
      csrmv_pkg::OP_CLOSE: keep = 1'b1;
      default:             keep = 1'b0;
    endcase
  end

  assign q_push_o  = accept && keep;
  assign q_entry_o = {in_item_i.operation, addr, in_item_i.datum[DATA_WIDTH-1:0]};

endmodule

`default_nettype wire

// ===== design/csrmv_queue.sv =====
// Short FIFO between the front end and the compute pipeline.
`timescale 1ns / 1ps
`default_nettype none

module csrmv_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = csrmv_pkg::QUEUE_DEPTH,
  localparam int unsigned PtrWidth = $clog2(DEPTH),
  localparam int unsigned CntWidth = $clog2(DEPTH + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic [WIDTH-1:0]  data_i,
  input  wire logic              pop_i,
  output logic [WIDTH-1:0]       data_o,
  output logic                   empty_o,
  output logic                   full_o
);

  logic [WIDTH-1:0]     slot_q [DEPTH];
  logic [PtrWidth-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0]  count_q, count_d;
  logic                 do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntWidth'(DEPTH));
  assign data_o  = slot_q[rd_ptr_q];
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/csrmv_back.sv =====
// Back end: vector store, multiplier, saturating accumulator and result register.
`timescale 1ns / 1ps
`default_nettype none

module csrmv_back #(
  parameter int unsigned VECTOR_DEPTH = csrmv_pkg::VECTOR_DEPTH_DEF,
  parameter int unsigned DATA_WIDTH   = csrmv_pkg::DATA_WIDTH_DEF,
  localparam int unsigned AddrWidth   = $clog2(VECTOR_DEPTH),
  localparam int unsigned EntryWidth  = 2 + AddrWidth + DATA_WIDTH
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [EntryWidth-1:0]  q_entry_i,
  input  wire logic                   q_empty_i,
  output logic                        q_pop_o,
  output logic                        out_valid_o,
  output csrmv_pkg::out_item_t        out_item_o,
  input  wire logic                   out_stall_i
);

  localparam int unsigned AccW  = csrmv_pkg::ACC_WIDTH;
  localparam int unsigned RndW  = AccW - csrmv_pkg::FRAC_BITS + 1;
  localparam int unsigned ProdW = 2 * DATA_WIDTH;
  localparam logic signed [RndW-1:0] SumMax =
    RndW'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
  localparam logic signed [RndW-1:0] SumMin =
    RndW'(-(64'sd1 <<< (DATA_WIDTH - 1)));
  localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW - 1){1'b1}}};
  localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW - 1){1'b0}}};

  // Head entry fields
  csrmv_pkg::op_e          head_op;
  logic [AddrWidth-1:0]    head_addr;
  logic [DATA_WIDTH-1:0]   head_datum;

  logic [DATA_WIDTH-1:0]        vec_mem_q [VECTOR_DEPTH];
  logic signed [DATA_WIDTH-1:0] rd_q;

  // Read stage
  logic                          r_valid_q, r_valid_d;
  csrmv_pkg::op_e                r_op_q;
  logic signed [DATA_WIDTH-1:0]  r_datum_q;

  // Multiply stage
  logic                     m_valid_q, m_valid_d;
  csrmv_pkg::op_e           m_op_q;
  logic signed [ProdW-1:0]  m_prod_q;
  logic signed [ProdW-1:0]  prod;

  // Accumulate stage
  logic signed [AccW-1:0]  acc_q, acc_d;
  logic                    clip_q, clip_d;
  logic [15:0]             row_cnt_q, row_cnt_d;
  logic                    out_valid_q, out_valid_d;
  csrmv_pkg::out_item_t    out_item_q, out_item_d;

  logic                    advance;
  logic                    fire_mac;
  logic                    fire_close;
  logic signed [AccW-1:0]  prod_ext;
  logic [AccW:0]           sum_wide;
  logic                    acc_ovf;
  logic signed [RndW-1:0]  rnd;
  logic signed [RndW-1:0]  rnd_sat;
  logic                    out_clip;

  assign head_op    = csrmv_pkg::op_e'(q_entry_i[EntryWidth-1 -: 2]);
  assign head_addr  = q_entry_i[DATA_WIDTH +: AddrWidth];
  assign head_datum = q_entry_i[DATA_WIDTH-1:0];

  // Freeze the whole pipe only when a close meets a result still waiting.
  assign advance = !(m_valid_q && (m_op_q == csrmv_pkg::OP_CLOSE) &&
                     out_valid_q && out_stall_i);
  assign q_pop_o = advance && !q_empty_i;

  assign fire_mac   = advance && m_valid_q && (m_op_q == csrmv_pkg::OP_MAC);
  assign fire_close = advance && m_valid_q && (m_op_q == csrmv_pkg::OP_CLOSE);

  always_ff @(posedge clk_i) begin
    if (q_pop_o && (head_op == csrmv_pkg::OP_LOAD)) begin
      vec_mem_q[head_addr] <= head_datum;
    end
    if (q_pop_o && (head_op == csrmv_pkg::OP_MAC)) begin
      rd_q <= vec_mem_q[head_addr];
    end
  end

  assign prod = r_datum_q * rd_q;

  // Saturating accumulate
  assign prod_ext = AccW'(m_prod_q);
  assign sum_wide = {acc_q[AccW-1], acc_q} + {prod_ext[AccW-1], prod_ext};
  assign acc_ovf  = sum_wide[AccW] ^ sum_wide[AccW-1];

  // Round half up to Q16.16, then clip to the data range.
  assign rnd = RndW'($signed(acc_q[AccW-1:csrmv_pkg::FRAC_BITS])) +
               {{(RndW - 1){1'b0}}, acc_q[csrmv_pkg::FRAC_BITS-1]};

  always_comb begin
    rnd_sat  = rnd;
    out_clip = 1'b0;
    if (rnd > SumMax) begin
      rnd_sat  = SumMax;
      out_clip = 1'b1;
    end else if (rnd < SumMin) begin
      rnd_sat  = SumMin;
      out_clip = 1'b1;
    end
  end

  always_comb begin
    r_valid_d   = r_valid_q;
    m_valid_d   = m_valid_q;
    acc_d       = acc_q;
    clip_d      = clip_q;
    row_cnt_d   = row_cnt_q;
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (advance) begin
      r_valid_d = q_pop_o;
      // Loads are done once written; drop them here.
      m_valid_d = r_valid_q && (r_op_q != csrmv_pkg::OP_LOAD);
    end
    if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (fire_mac) begin
      if (acc_ovf) begin
        acc_d  = prod_ext[AccW-1] ? AccMin : AccMax;
        clip_d = 1'b1;
      end else begin
        acc_d = AccW'(sum_wide);
      end
    end
    if (fire_close) begin
      out_valid_d           = 1'b1;
      out_item_d.row_sum    = 32'(rnd_sat);
      out_item_d.row_number = row_cnt_q;
      out_item_d.saturated  = clip_q || out_clip;
      acc_d                 = '0;
      clip_d                = 1'b0;
      row_cnt_d             = row_cnt_q + 16'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q   <= 1'b0;
      m_valid_q   <= 1'b0;
      acc_q       <= '0;
      clip_q      <= 1'b0;
      row_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      r_valid_q   <= r_valid_d;
      m_valid_q   <= m_valid_d;
      acc_q       <= acc_d;
      clip_q      <= clip_d;
      row_cnt_q   <= row_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
    if (advance) begin
      r_op_q    <= head_op;
      r_datum_q <= head_datum;
      m_op_q    <= r_op_q;
      m_prod_q  <= prod;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

// ===== design/csr_sparse_matvec_row_engine.sv =====
// Top level of the CSR sparse matrix times dense vector row engine.
// Usage: items enter on in_valid_i / in_item_i and are accepted at an edge
// where in_valid_i is high and in_stall_o is low. An item loads a vector
// entry, multiplies a nonzero by the stored entry at its column and adds it
// to the row accumulator, or closes the row. Only a close gives a result,
// presented on out_valid_o / out_item_o and taken at an edge where
// out_stall_i is low. Items with the unused code, and loads and nonzeros
// past the store, are accepted and dropped.
// Throughput: one item per cycle when not stalled; the store has one write
// or one read port used per item and the multiplier is fully pipelined.
// A close item passes the queue, store read, multiply and accumulate/round
// stages in order before its result is shown.
// Reset clears the accumulator, row counter, clip flag, queue and result
// valid; the vector store is not cleared and must be loaded before use.
// A stalled result holds; the pipe behind it freezes only when another
// close reaches it, and the 4-entry queue then fills and raises in_stall_o.
`timescale 1ns / 1ps
`default_nettype none

module csr_sparse_matvec_row_engine #(
  parameter int unsigned VECTOR_DEPTH = csrmv_pkg::VECTOR_DEPTH_DEF,
  parameter int unsigned DATA_WIDTH   = csrmv_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire csrmv_pkg::in_item_t   in_item_i,
  output logic                       in_stall_o,
  output logic                       out_valid_o,
  output csrmv_pkg::out_item_t       out_item_o,
  input  wire logic                  out_stall_i
);

  localparam int unsigned AddrWidth  = $clog2(VECTOR_DEPTH);
  localparam int unsigned EntryWidth = 2 + AddrWidth + DATA_WIDTH;

  logic                   q_full;
  logic                   q_empty;
  logic                   q_push;
  logic                   q_pop;
  logic [EntryWidth-1:0]  q_entry_in;
  logic [EntryWidth-1:0]  q_entry_out;

  csrmv_front #(
    .VECTOR_DEPTH (VECTOR_DEPTH),
    .DATA_WIDTH   (DATA_WIDTH)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (q_entry_in)
  );

  csrmv_queue #(
    .WIDTH (EntryWidth),
    .DEPTH (csrmv_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_entry_in),
    .pop_i   (q_pop),
    .data_o  (q_entry_out),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  csrmv_back #(
    .VECTOR_DEPTH (VECTOR_DEPTH),
    .DATA_WIDTH   (DATA_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_entry_i   (q_entry_out),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i)
  );

endmodule

`default_nettype wire

// ===== design/csrmv_checker.sv =====
// Port-level checks for the CSR sparse row engine, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module csrmv_checker #(
  parameter int unsigned DATA_WIDTH = csrmv_pkg::DATA_WIDTH_DEF
) (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire csrmv_pkg::in_item_t   in_item_i,
  input wire logic                  in_stall_o,
  input wire logic                  out_valid_o,
  input wire csrmv_pkg::out_item_t  out_item_o,
  input wire logic                  out_stall_i
);

  localparam logic signed [31:0] SumMax = 32'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
  localparam logic signed [31:0] SumMin = 32'(-(64'sd1 <<< (DATA_WIDTH - 1)));

  logic         out_take;
  logic         seen_q;
  logic [15:0]  last_q;

  assign out_take = out_valid_o && !out_stall_i;

  // Track the row number of the last delivered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
      last_q <= '0;
    end else if (out_take) begin
      seen_q <= 1'b1;
      last_q <= out_item_o.row_number;
    end
  end

  a_held_while_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("result changed while stalled");

  a_rows_in_sequence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_take && seen_q) |-> (out_item_o.row_number == last_q + 16'd1))
    else $error("row number skipped or repeated");

  a_sum_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.row_sum <= SumMax && out_item_o.row_sum >= SumMin))
    else $error("row sum outside data range");

  a_quiet_in_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result shown during reset");

endmodule

bind csr_sparse_matvec_row_engine csrmv_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_checker (.*);

`default_nettype wire

// ===== sim/csr_sparse_matvec_row_engine_tb.sv =====
// Self-checking testbench for the CSR sparse row engine, checking each row result against a model.
`timescale 1ns / 1ps

module csr_sparse_matvec_row_engine_tb;
  import csrmv_pkg::*;

  localparam int unsigned VDEPTH      = VECTOR_DEPTH_DEF;
  localparam int unsigned DW          = DATA_WIDTH_DEF;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned TAIL_CYCLES = 8;

  logic      clk       = 1'b0;
  logic      rst_n;
  logic      in_valid  = 1'b0;
  in_item_t  in_item   = '0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_item;
  logic      out_stall = 1'b0;

  // Sender and receiver idling controls, and the request for a long output hold.
  bit tx_idle   = 1'b0;
  bit rx_random = 1'b0;
  bit hold_req  = 1'b0;

  // Behavioral copy of the engine state.
  logic [31:0]        vec_mem [VDEPTH];
  logic signed [63:0] acc_q;
  logic [15:0]        rows_closed;
  logic               clip_seen;
  out_item_t          row_sums_due [$];

  // Positions loaded so far; nonzeros only read from these.
  bit loaded [VDEPTH];
  int loaded_pos [$];

  int unsigned items_sent   = 0;
  int unsigned rows_checked = 0;
  int unsigned clipped_rows = 0;
  int unsigned mismatches   = 0;

  csr_sparse_matvec_row_engine #(
    .VECTOR_DEPTH(VDEPTH),
    .DATA_WIDTH  (DW)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_item_i  (in_item),
    .in_stall_o (in_stall),
    .out_valid_o(out_valid),
    .out_item_o (out_item),
    .out_stall_i(out_stall)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Timed out with %0d row results still due", row_sums_due.size());
    $display("Mismatches found");
    $finish;
  end

  function automatic logic signed [63:0] sext_data(logic [31:0] v);
    logic signed [31:0] t;
    t = $signed(v << (32 - DW)) >>> (32 - DW);
    return t;
  endfunction

  // Advance the model by one accepted item; queue the row result on a close.
  function automatic void step_matvec(in_item_t it);
    logic signed [63:0] d;
    logic signed [63:0] x;
    logic signed [63:0] prod;
    logic signed [63:0] q;
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    logic signed [64:0] s;
    out_item_t          res;
    d = sext_data(it.datum);
    case (it.operation)
      OP_LOAD: begin
        if (it.position < VDEPTH) vec_mem[it.position] = d[31:0];
      end
      OP_MAC: begin
        if (it.position < VDEPTH) begin
          x    = sext_data(vec_mem[it.position]);
          prod = d * x;
          s    = acc_q + prod;
          if (s[64] != s[63]) begin
            acc_q     = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            clip_seen = 1'b1;
          end else begin
            acc_q = s[63:0];
          end
        end
      end
      OP_CLOSE: begin
        // Round half up: floor of the shift plus the first dropped bit.
        q  = acc_q >>> FRAC_BITS;
        q  = q + acc_q[FRAC_BITS-1];
        hi = (64'sd1 <<< (DW - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (q > hi) begin
          q         = hi;
          clip_seen = 1'b1;
        end else if (q < lo) begin
          q         = lo;
          clip_seen = 1'b1;
        end
        res.row_sum    = q[31:0];
        res.row_number = rows_closed;
        res.saturated  = clip_seen;
        row_sums_due   = {row_sums_due, res};
        rows_closed    = rows_closed + 16'd1;
        acc_q          = '0;
        clip_seen      = 1'b0;
      end
      default: ;
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  // Mostly small Q16.16 values so that many rows stay in range.
  function automatic logic [31:0] rand_datum();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 7) return 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
    if (r < 9) return $urandom();
    case ($urandom_range(0, 3))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [9:0] pick_loaded();
    return 10'(loaded_pos[$urandom_range(0, loaded_pos.size() - 1)]);
  endfunction

  function automatic void report_mismatch(string what, out_item_t want, out_item_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: expected sum %h row %0d sat %0b, got sum %h row %0d sat %0b",
               $realtime, what, want.row_sum, want.row_number, want.saturated,
               got.row_sum, got.row_number, got.saturated);
  endfunction

  task automatic idle_cycles(input int unsigned n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // Offer one item and hold it until the engine takes it; valid stays high after.
  task automatic send_item(input logic [1:0] op, input logic [9:0] pos, input logic [31:0] d);
    in_item_t it;
    it.operation = op;
    it.position  = pos;
    it.datum     = d;
    if (tx_idle) idle_cycles(pick_gap());
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    step_matvec(it);
    items_sent++;
    if (op == OP_LOAD && !loaded[pos]) begin
      loaded[pos] = 1'b1;
      loaded_pos  = {loaded_pos, int'(pos)};
    end
  endtask

  // Stop offering and wait for every due row result, then let the pipe settle.
  task automatic wait_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (row_sums_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Receiver: random stall runs, or a long hold when requested.
  initial begin : receiver
    int unsigned hold_left;
    int unsigned stall_left;
    logic        nxt;
    hold_left  = 0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        nxt = 1'b1;
      end else if (!rx_random) begin
        nxt = 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        nxt = 1'b1;
      end else if ($urandom_range(0, 2) == 0) begin
        stall_left = pick_gap();
        nxt        = (stall_left != 0);
      end else begin
        nxt = 1'b0;
      end
      out_stall <= nxt;
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (row_sums_due.size() == 0) begin
        report_mismatch("row result with none due", '0, out_item);
      end else begin
        want = row_sums_due.pop_front();
        rows_checked++;
        if (want.saturated) clipped_rows++;
        if (out_item.row_sum !== want.row_sum || out_item.row_number !== want.row_number ||
            out_item.saturated !== want.saturated)
          report_mismatch("row result differs", want, out_item);
      end
    end
  end

  task automatic test_directed();
    tx_idle   = 1'b1;
    rx_random = 1'b1;
    // Empty row gives zero.
    send_item(OP_CLOSE, 10'd0, 32'h0000_0000);
    send_item(OP_LOAD, 10'd0, 32'h0001_0000);
    send_item(OP_LOAD, 10'd1, 32'h7FFF_FFFF);
    send_item(OP_LOAD, 10'd2, 32'h0000_0001);
    send_item(OP_LOAD, 10'd1023, 32'h8000_0000);
    send_item(OP_MAC, 10'd0, 32'h0002_8000);
    send_item(OP_CLOSE, 10'd0, 32'h0000_0000);
    // Halfway cases round toward plus infinity, on both signs.
    send_item(OP_MAC, 10'd2, 32'h0000_8000);
    send_item(OP_CLOSE, 10'd0, 32'h0000_0000);
    send_item(OP_MAC, 10'd2, 32'hFFFF_8000);
    send_item(OP_CLOSE, 10'd0, 32'h0000_0000);
    // Clip on output only.
    send_item(OP_MAC, 10'd1, 32'h7FFF_FFFF);
    send_item(OP_CLOSE, 10'd0, 32'h0000_0000);
    // Clip the accumulator at its top limit.
    send_item(OP_MAC, 10'd1023, 32'h8000_0000);
    send_item(OP_MAC, 10'd1023, 32'h8000_0000);
    send_item(OP_CLOSE, 10'd0, 32'h0000_0000);
    // Clip the accumulator at its bottom limit.
    repeat (3) send_item(OP_MAC, 10'd1023, 32'h7FFF_FFFF);
    send_item(OP_CLOSE, 10'd1023, 32'hFFFF_FFFF);
    // Unused code must leave the row untouched.
    send_item(OP_UNUSED, 10'h3FF, 32'hFFFF_FFFF);
    send_item(OP_CLOSE, 10'd0, 32'h0000_0000);
    // Overwrite a loaded entry.
    send_item(OP_LOAD, 10'd0, 32'hFFFF_0000);
    send_item(OP_MAC, 10'd0, 32'h0001_0000);
    send_item(OP_CLOSE, 10'd0, 32'h0000_0000);
    wait_drain();
  endtask

  // Well-formed CSR rows with random content, mixed with loads and dropped codes.
  task automatic test_random_rows(input int n, input bit idle);
    int done;
    int nnz;
    int r;
    done      = 0;
    tx_idle   = idle;
    rx_random = idle;
    repeat (16) send_item(OP_LOAD, 10'($urandom_range(0, VDEPTH - 1)), rand_datum());
    done = 16;
    while (done < n) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        send_item(OP_LOAD, 10'($urandom_range(0, VDEPTH - 1)), rand_datum());
        done++;
      end else if (r < 15) begin
        send_item(OP_UNUSED, 10'($urandom()), rand_datum());
      end else begin
        nnz = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
        repeat (nnz) send_item(OP_MAC, pick_loaded(), rand_datum());
        // Reload an entry in the middle of a row now and then.
        if (r >= 95) begin
          send_item(OP_LOAD, pick_loaded(), rand_datum());
          send_item(OP_MAC, pick_loaded(), rand_datum());
          done += 2;
        end
        send_item(OP_CLOSE, 10'($urandom()), $urandom());
        done += nnz + 1;
      end
      if ($urandom_range(0, 49) == 0) wait_drain();
    end
    wait_drain();
  endtask

  // Hold the output for a long stretch while short rows keep coming.
  task automatic test_backpressure();
    tx_idle   = 1'b0;
    rx_random = 1'b0;
    hold_req  = 1'b1;
    repeat (48) begin
      send_item(OP_MAC, pick_loaded(), rand_datum());
      send_item(OP_CLOSE, 10'($urandom()), $urandom());
    end
    wait_drain();
  endtask

  initial begin
    rst_n       <= 1'b0;
    acc_q       = '0;
    rows_closed = '0;
    clip_seen   = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_rows(700, 1'b1);
    test_backpressure();
    test_random_rows(250, 1'b0);
    test_random_rows(380, 1'b1);

    $display("Sent %0d items: rounding and clipping cases, random CSR rows with reloads",
             items_sent);
    $display("and idling, and a %0d-cycle output hold; %0d rows checked, %0d of them clipped",
             HOLD_CYCLES, rows_checked, clipped_rows);
    if (mismatches == 0 && row_sums_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/csrmv_pkg.sv
design/csrmv_front.sv
design/csrmv_queue.sv
design/csrmv_back.sv
design/csr_sparse_matvec_row_engine.sv
design/csrmv_checker.sv
sim/csr_sparse_matvec_row_engine_tb.sv
